// ----- sv/assert_macros.svh -----
// Assertion macros shared by the stepper sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DSWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DSWS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/dsws_pkg.sv -----
// Shared types, constants and helpers of the dual stepper wave sequencer.
package dsws_pkg;

   // Width of step counts and step sums.
   localparam int STEP_W = 16;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_HALF_PERIOD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEPS_PER_MM = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_SMALL = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_LARGE = 4'd3;

   // Request kinds.
   localparam logic REQ_MOTION = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Motion codes.
   localparam logic [1:0] MOT_FORWARD  = 2'd0;
   localparam logic [1:0] MOT_BACKWARD = 2'd1;
   localparam logic [1:0] MOT_LEFT     = 2'd2;
   localparam logic [1:0] MOT_RIGHT    = 2'd3;

   // Number of greedy degree chunks and the index of the largest.
   localparam int CHUNK_N = 8;
   localparam logic [2:0] CHUNK_TOP = 3'(CHUNK_N - 1);

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_COMMIT
   } seq_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch;      // capture the request beat
      logic calc_step;  // one greedy chunk step
      logic commit;     // apply the item and load the result register
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic calc_done;  // step count of the latched item is ready
   } dp_status_type;

   // Degrees of greedy chunk k, smallest first.
   function automatic logic [7:0] chunk_deg(input logic [2:0] k);
      logic [7:0] d;
      unique case (k)
         3'd0: d = 8'd1;
         3'd1: d = 8'd5;
         3'd2: d = 8'd10;
         3'd3: d = 8'd15;
         3'd4: d = 8'd30;
         3'd5: d = 8'd45;
         3'd6: d = 8'd90;
         3'd7: d = 8'd180;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

endpackage

// ----- sv/dsws_channels.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface dsws_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  motion;
   logic [15:0] amount;

   modport source (output valid, req_type, motion, amount, input ready);
   modport sink (input valid, req_type, motion, amount, output ready);
endinterface

interface dsws_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] left_coils;
   logic [3:0] right_coils;
   logic       busy_res;
   logic       accepted;
   logic       done_res;

   modport source (output valid, left_coils, right_coils, busy_res, accepted, done_res,
                   input ready);
   modport sink (input valid, left_coils, right_coils, busy_res, accepted, done_res,
                 output ready);
endinterface

// ----- sv/dsws_dp.sv -----
// Datapath: config registers, degree splitter, motion state and result register.
`include "assert_macros.svh"

module dsws_dp import dsws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  req_type,
   input  logic [1:0]            motion,
   input  logic [15:0]           amount,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [3:0]            left_coils,
   output logic [3:0]            right_coils,
   output logic                  busy_res,
   output logic                  accepted,
   output logic                  done_res
);

   // Configuration registers
   logic [7:0]            half_period_ff;
   logic [7:0]            steps_per_mm_ff;
   logic [CSR_DATA_W-1:0] angle_small_ff;
   logic [CSR_DATA_W-1:0] angle_large_ff;

   // Latched request beat
   logic        rq_type_ff;
   logic [1:0]  rq_motion_ff;
   logic [15:0] rq_amount_ff;

   // Degree splitter
   logic [15:0]       deg_ff, deg_in;
   logic [STEP_W-1:0] sum_ff, sum_in;
   logic [2:0]        k_ff, k_in;
   logic              calc_end_ff, calc_end_in;

   // Motion state
   logic              active_ff, active_in;
   logic [1:0]        cur_motion_ff, cur_motion_in;
   logic [STEP_W-1:0] steps_left_ff, steps_left_in;
   logic [1:0]        phase_ff, phase_in;
   logic              high_ff, high_in;
   logic [7:0]        tick_ff, tick_in;

   // Result register
   logic [3:0] left_ff, left_in;
   logic [3:0] right_ff, right_in;
   logic       busy_ff, acc_ff, acc_in, done_ff, done_in;

   logic [7:0]        cdeg;
   logic [15:0]       csteps;
   logic [23:0]       straight_prod;
   logic [STEP_W-1:0] n_steps;
   logic [7:0]        half_eff;
   logic [7:0]        tick_inc;
   logic [1:0]        lc, rc;
   logic              need_calc;

   // Config writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff  <= 8'd2;
         steps_per_mm_ff <= 8'd1;
         angle_small_ff  <= '0;
         angle_large_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HALF_PERIOD:  half_period_ff  <= csr_wdata[7:0];
            REG_STEPS_PER_MM: steps_per_mm_ff <= csr_wdata[7:0];
            REG_ANGLE_SMALL:  angle_small_ff  <= csr_wdata;
            REG_ANGLE_LARGE:  angle_large_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_type_ff   <= req_type;
         rq_motion_ff <= motion;
         rq_amount_ff <= amount;
      end
   end

   // Greedy split: take one chunk per cycle while it fits, else move to a smaller one
   always_comb begin
      cdeg   = chunk_deg(k_ff);
      csteps = k_ff[2] ? angle_large_ff[16*k_ff[1:0] +: 16]
                       : angle_small_ff[16*k_ff[1:0] +: 16];
      deg_in      = deg_ff;
      sum_in      = sum_ff;
      k_in        = k_ff;
      calc_end_in = calc_end_ff;
      if (cmd.latch) begin
         deg_in      = amount;
         sum_in      = '0;
         k_in        = CHUNK_TOP;
         calc_end_in = 1'b0;
      end else if (cmd.calc_step) begin
         if (deg_ff >= 16'(cdeg)) begin
            deg_in = deg_ff - 16'(cdeg);
            sum_in = sum_ff + STEP_W'(csteps);
         end else if (k_ff == 3'd0) begin
            calc_end_in = 1'b1;
         end else begin
            k_in = k_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      deg_ff <= deg_in;
      sum_ff <= sum_in;
      k_ff   <= k_in;
      if (reset) calc_end_ff <= 1'b0;
      else       calc_end_ff <= calc_end_in;
   end

   // Only a turn command taken while idle needs the splitter
   assign need_calc = (rq_type_ff == REQ_MOTION) && rq_motion_ff[1] && !active_ff;
   assign status.calc_done = !need_calc || calc_end_ff;

   // Item commit: start a motion, refuse a command while busy, or advance the wave on a tick
   always_comb begin
      straight_prod = rq_amount_ff * steps_per_mm_ff;
      n_steps  = rq_motion_ff[1] ? (sum_ff >> 1) : STEP_W'(straight_prod);
      half_eff = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
      tick_inc = tick_ff + 8'd1;

      active_in     = active_ff;
      cur_motion_in = cur_motion_ff;
      steps_left_in = steps_left_ff;
      phase_in      = phase_ff;
      high_in       = high_ff;
      tick_in       = tick_ff;
      acc_in        = 1'b0;
      done_in       = 1'b0;

      if (rq_type_ff == REQ_MOTION) begin
         if (!active_ff) begin
            acc_in = 1'b1;
            if (n_steps == '0) begin
               done_in = 1'b1;
            end else begin
               active_in     = 1'b1;
               cur_motion_in = rq_motion_ff;
               steps_left_in = n_steps;
               phase_in      = 2'd0;
               high_in       = 1'b1;
               tick_in       = 8'd0;
            end
         end
      end else if (active_ff) begin
         tick_in = tick_inc;
         if (tick_inc >= half_eff) begin
            tick_in = 8'd0;
            if (high_ff) begin
               high_in = 1'b0;
            end else begin
               steps_left_in = steps_left_ff - STEP_W'(1);
               phase_in      = phase_ff + 2'd1;
               if (steps_left_ff == STEP_W'(1)) begin
                  active_in = 1'b0;
                  done_in   = 1'b1;
               end else begin
                  high_in = 1'b1;
               end
            end
         end
      end

      // Coil drive from the state after this item
      unique case (cur_motion_in)
         MOT_FORWARD:  begin lc = phase_in;        rc = phase_in;        end
         MOT_BACKWARD: begin lc = 2'd3 - phase_in; rc = 2'd3 - phase_in; end
         MOT_LEFT:     begin lc = 2'd3 - phase_in; rc = phase_in;        end
         MOT_RIGHT:    begin lc = phase_in;        rc = 2'd3 - phase_in; end
         default:      begin lc = phase_in;        rc = phase_in;        end
      endcase
      if (active_in && high_in) begin
         left_in  = 4'b0001 << lc;
         right_in = 4'b0001 << rc;
      end else begin
         left_in  = 4'd0;
         right_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         cur_motion_ff <= MOT_FORWARD;
         steps_left_ff <= '0;
         phase_ff      <= 2'd0;
         high_ff       <= 1'b0;
         tick_ff       <= 8'd0;
      end else if (cmd.commit) begin
         active_ff     <= active_in;
         cur_motion_ff <= cur_motion_in;
         steps_left_ff <= steps_left_in;
         phase_ff      <= phase_in;
         high_ff       <= high_in;
         tick_ff       <= tick_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         busy_ff  <= active_in;
         acc_ff   <= acc_in;
         done_ff  <= done_in;
      end
   end

   assign left_coils  = left_ff;
   assign right_coils = right_ff;
   assign busy_res    = busy_ff;
   assign accepted    = acc_ff;
   assign done_res    = done_ff;

   `DSWS_ASSERT(a_active_has_steps, active_ff |-> (steps_left_ff != '0), "running motion with no steps left")
   `DSWS_ASSERT(a_calc_only_when_needed, cmd.calc_step |-> !calc_end_ff, "split step after the split ended")

endmodule

// ----- sv/dsws_ctrl.sv -----
// Controller state machine: request intake, split sequencing and result handoff.
`include "assert_macros.svh"

module dsws_ctrl import dsws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   seq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State register and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            if (status.calc_done) state_in = S_COMMIT;
            else                  cmd.calc_step = 1'b1;
         end
         S_COMMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   `DSWS_ASSERT(a_accept_to_calc, (req_valid && req_ready) |=> (state_ff == S_CALC), "accepted beat did not start work")
   `DSWS_ASSERT(a_no_overwrite, cmd.commit |-> (!rsp_valid_ff || rsp_ready), "result overwritten before taken")
   `DSWS_ASSERT_ALWAYS(a_rsp_from_commit, (!reset && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_COMMIT), "result without commit")

endmodule

// ----- sv/dual_stepper_wave_sequencer.sv -----
// Dual four-coil stepper sequencer, wave drive.
// Request channel (req_bus): one beat per item. req_type 0 is a motion command
// (motion, amount), req_type 1 is one time tick. Response channel (rsp_bus):
// exactly one beat per request with the coil drive after that item, busy,
// accepted and done flags. Configuration (csr_we/csr_index/csr_wdata) writes
// half period, steps per mm and the two angle step tables; write it while
// no request is in flight.
// A tick, straight move or rejected command passes the CALC and COMMIT states
// on its way to the result register. A turn command runs the greedy degree
// splitter in CALC, one chunk step per cycle.
// One item is in work at a time; req ready is high only in the idle state,
// so the next beat is taken in the cycle after the commit at the earliest.
// When the receiver stalls, the finished result waits in the result
// register and the controller holds the next item before its commit.
// Reset (synchronous, active high) stops any motion, drops a pending
// result and restores the register defaults (half period 2, 1 step/mm).
module dual_stepper_wave_sequencer import dsws_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dsws_req_if.sink              req_bus,
   dsws_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller
   dsws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath
   dsws_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_bus.req_type),
      .motion      (req_bus.motion),
      .amount      (req_bus.amount),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .left_coils  (rsp_bus.left_coils),
      .right_coils (rsp_bus.right_coils),
      .busy_res    (rsp_bus.busy_res),
      .accepted    (rsp_bus.accepted),
      .done_res    (rsp_bus.done_res)
   );

endmodule

// ----- tb/dual_stepper_wave_sequencer_tb.sv -----
// Self-checking testbench for the dual stepper wave sequencer: directed and random traffic.
`timescale 1ns / 1ps

module dual_stepper_wave_sequencer_tb;
   import dsws_pkg::*;

   localparam int CLK_HALF_NS  = 6;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 900;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int CYCLE_LIMIT  = 4_000_000;

   // first register index that the block does not implement
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_INDEX   = 4'd15;

   // chunk sizes in degrees, smallest in the low byte
   localparam logic [63:0] CHUNK_DEG_LIST =
      {8'd180, 8'd90, 8'd45, 8'd30, 8'd15, 8'd10, 8'd5, 8'd1};

   typedef struct packed {
      logic [3:0] left_coils;
      logic [3:0] right_coils;
      logic       busy_res;
      logic       accepted;
      logic       done_res;
   } coil_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dsws_req_if req_bus ();
   dsws_rsp_if rsp_bus ();

   dual_stepper_wave_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register shadow
   logic [7:0]  half_period;
   logic [7:0]  mm_steps;
   logic [63:0] ang_small;
   logic [63:0] ang_large;

   // motion state of the predictor
   logic        run_active;
   logic [1:0]  run_motion;
   logic [15:0] run_steps;
   logic [1:0]  run_phase;
   logic        run_high;
   logic [7:0]  run_ticks;

   coil_report_type expected_coils_q[$];
   int unsigned  errors = 0;
   int unsigned  cycles = 0;
   int unsigned  worked_items = 0;
   int unsigned  req_calm = 0;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF_NS clock = ~clock;
   end

   // idle length: mostly short, a few long, now and then a calm stretch
   function automatic int unsigned draw_gap(inout int unsigned calm_left);
      int unsigned pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) calm_left = $urandom_range(20, 80);
      if (pick < 50) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // step count of a command under the current registers
   function automatic logic [15:0] move_steps(input logic [1:0] mot, input logic [15:0] amt);
      logic [31:0] rest, cnt, deg, prod;
      logic [63:0] tbl;
      logic [15:0] sum;
      if (mot == MOT_FORWARD || mot == MOT_BACKWARD) begin
         prod = 32'(amt) * 32'(mm_steps);
         return prod[15:0];
      end
      rest = 32'(amt);
      sum  = '0;
      // greedy split, largest chunk first, sums wrap at 16 bits
      for (int k = CHUNK_N - 1; k >= 0; k--) begin
         deg  = 32'(CHUNK_DEG_LIST[k*8 +: 8]);
         cnt  = rest / deg;
         rest = rest - cnt * deg;
         tbl  = (k < 4) ? ang_small : ang_large;
         prod = cnt * 32'(tbl[(k % 4)*16 +: 16]);
         sum  = sum + prod[15:0];
      end
      return sum >> 1;
   endfunction

   // apply one accepted beat to the predictor and queue its result
   task automatic advance_sequencer(input logic kind, input logic [1:0] mot,
                                    input logic [15:0] amt);
      coil_report_type rpt;
      logic [15:0]  n;
      logic [7:0]   h;
      logic [1:0]   fwd, rev;
      rpt = '0;
      if (kind == REQ_MOTION) begin
         worked_items++;
         if (!run_active) begin
            n = move_steps(mot, amt);
            rpt.accepted = 1'b1;
            if (n == 16'd0) begin
               rpt.done_res = 1'b1;
            end else begin
               run_active = 1'b1;
               run_motion = mot;
               run_steps  = n;
               run_phase  = 2'd0;
               run_high   = 1'b1;
               run_ticks  = 8'd0;
            end
         end
      end else if (run_active) begin
         worked_items++;
         h = (half_period == 8'd0) ? 8'd1 : half_period;
         run_ticks = run_ticks + 8'd1;
         if (run_ticks >= h) begin
            run_ticks = 8'd0;
            if (run_high) begin
               run_high = 1'b0;
            end else begin
               run_steps = run_steps - 16'd1;
               run_phase = run_phase + 2'd1;
               if (run_steps == 16'd0) begin
                  run_active = 1'b0;
                  rpt.done_res = 1'b1;
               end else begin
                  run_high = 1'b1;
               end
            end
         end
      end
      // wave drive: reversed wheel counts coils down
      if (run_active && run_high) begin
         fwd = run_phase;
         rev = 2'd3 - run_phase;
         case (run_motion)
            MOT_FORWARD: begin
               rpt.left_coils  = 4'b1 << fwd;
               rpt.right_coils = 4'b1 << fwd;
            end
            MOT_BACKWARD: begin
               rpt.left_coils  = 4'b1 << rev;
               rpt.right_coils = 4'b1 << rev;
            end
            MOT_LEFT: begin
               rpt.left_coils  = 4'b1 << rev;
               rpt.right_coils = 4'b1 << fwd;
            end
            default: begin
               rpt.left_coils  = 4'b1 << fwd;
               rpt.right_coils = 4'b1 << rev;
            end
         endcase
      end
      rpt.busy_res = run_active;
      expected_coils_q.push_back(rpt);
   endtask

   // one request beat, with a random idle gap ahead of it
   task automatic send_item(input logic kind, input logic [1:0] mot, input logic [15:0] amt);
      int unsigned gap;
      gap = draw_gap(req_calm);
      repeat (gap + 1) @(posedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.motion   <= mot;
      req_bus.amount   <= amt;
      do @(posedge clock); while (!req_bus.ready);
      req_bus.valid <= 1'b0;
      advance_sequencer(kind, mot, amt);
   endtask

   // tick beats carry random junk in the unused fields
   task automatic send_tick();
      send_item(REQ_TICK, 2'($urandom), 16'($urandom));
   endtask

   task automatic run_out_motion();
      while (run_active) send_tick();
   endtask

   // nothing in flight: every expected beat came back
   task automatic wait_bus_idle();
      while (expected_coils_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only land once every earlier beat has come back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      wait_bus_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_HALF_PERIOD:  half_period = value[7:0];
         REG_STEPS_PER_MM: mm_steps    = value[7:0];
         REG_ANGLE_SMALL:  ang_small   = value;
         REG_ANGLE_LARGE:  ang_large   = value;
         default: ;
      endcase
   endtask

   function automatic logic [7:0] pick_half_period();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 10) return 8'd0;
      if (p < 80) return 8'($urandom_range(1, 3));
      if (p < 95) return 8'($urandom_range(4, 8));
      return 8'($urandom_range(9, 40));
   endfunction

   function automatic logic [7:0] pick_mm_steps();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 15) return 8'd0;
      if (p < 60) return 8'($urandom_range(1, 4));
      if (p < 80) return 8'($urandom_range(5, 40));
      if (p < 90) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   // step table: mostly small counts, some zero, wrap-friendly and full-range entries
   function automatic logic [63:0] pick_angle_table();
      logic [63:0] tbl;
      int unsigned p;
      for (int e = 0; e < 4; e++) begin
         p = $urandom_range(0, 99);
         if (p < 15)      tbl[e*16 +: 16] = 16'd0;
         else if (p < 65) tbl[e*16 +: 16] = 16'($urandom_range(1, 6));
         else if (p < 75) tbl[e*16 +: 16] = 16'hFFFF;
         else if (p < 85) tbl[e*16 +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h4000;
         else             tbl[e*16 +: 16] = 16'($urandom);
      end
      return tbl;
   endfunction

   // amount whose motion stays short enough to run out
   function automatic logic [15:0] pick_amount(input logic [1:0] mot);
      logic [15:0] cand;
      int unsigned lim, p;
      lim = (half_period > 8'd8) ? 3 : 16;
      for (int t = 0; t < 12; t++) begin
         p = $urandom_range(0, 99);
         if (p < 50)      cand = 16'($urandom);
         else if (p < 80) cand = 16'($urandom_range(0, 400));
         else             cand = 16'($urandom_range(0, 20));
         if (move_steps(mot, cand) <= lim) return cand;
      end
      return 16'd0;
   endfunction

   // defaults after reset, idle tick, one step, command refused while busy
   task automatic test_power_on_defaults();
      send_tick();
      send_item(REQ_MOTION, MOT_FORWARD, 16'd1);
      send_item(REQ_MOTION, MOT_BACKWARD, 16'hFFFF);
      run_out_motion();
   endtask

   // step sums wrapping to zero and zero-length moves finish at once
   task automatic test_step_wrap();
      write_reg(REG_STEPS_PER_MM, 64'd2);
      send_item(REQ_MOTION, MOT_FORWARD, 16'h8000);
      send_item(REQ_MOTION, MOT_BACKWARD, 16'd0);
      write_reg(REG_STEPS_PER_MM, 64'd0);
      send_item(REQ_MOTION, MOT_FORWARD, 16'hFFFF);
   endtask

   // turns: largest angle, halving of an odd sum, zero half period
   task automatic test_turns();
      write_reg(REG_HALF_PERIOD, 64'd0);
      write_reg(REG_ANGLE_SMALL, {16'd2, 16'd6, 16'd4, 16'd3});
      write_reg(REG_ANGLE_LARGE, {16'h4000, 16'd16, 16'd12, 16'd10});
      send_item(REQ_MOTION, MOT_LEFT, 16'hFFFF);
      run_out_motion();
      send_item(REQ_MOTION, MOT_RIGHT, 16'd1);
      run_out_motion();
   endtask

   // register extremes, unused index, half period shortened mid-motion
   task automatic test_register_extremes();
      write_reg(REG_HALF_PERIOD, 64'd255);
      write_reg(REG_STEPS_PER_MM, 64'd255);
      write_reg(REG_ANGLE_SMALL, '1);
      write_reg(REG_ANGLE_LARGE, '1);
      write_reg(REG_FIRST_UNUSED, 64'd1);
      send_item(REQ_MOTION, MOT_LEFT, 16'd0);
      // 65279 * 255 wraps to a single step
      send_item(REQ_MOTION, MOT_FORWARD, 16'd65279);
      repeat (3) send_tick();
      wait_bus_idle();
      write_reg(REG_HALF_PERIOD, 64'd2);
      run_out_motion();
   endtask

   task automatic test_random_traffic();
      int unsigned goal, burst, p;
      goal = worked_items + RANDOM_ITEMS;
      while (worked_items < goal) begin
         wait_bus_idle();
         // new settings for this phase; junk above the 8-bit registers
         if ($urandom_range(0, 1))
            write_reg(REG_HALF_PERIOD, {{$urandom, $urandom} & ~64'hFF} | pick_half_period());
         if ($urandom_range(0, 1))
            write_reg(REG_STEPS_PER_MM, {{$urandom, $urandom} & ~64'hFF} | pick_mm_steps());
         if ($urandom_range(0, 2) == 0) write_reg(REG_ANGLE_SMALL, pick_angle_table());
         if ($urandom_range(0, 2) == 0) write_reg(REG_ANGLE_LARGE, pick_angle_table());
         if ($urandom_range(0, 9) == 0)
            write_reg(4'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
                      {$urandom, $urandom});
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            p = $urandom_range(0, 99);
            if (!run_active) begin
               if (p < 80) begin
                  p = $urandom_range(0, 3);
                  send_item(REQ_MOTION, 2'(p), pick_amount(2'(p)));
               end else begin
                  send_tick();
               end
            end else if (p < 85) begin
               send_tick();
            end else if (p < 96) begin
               send_item(REQ_MOTION, 2'($urandom), 16'($urandom));
            end else begin
               wait_bus_idle();
               write_reg(REG_HALF_PERIOD, 64'($urandom_range(0, 8)));
            end
         end
         run_out_motion();
      end
   endtask

   // result side backpressure
   initial begin
      int unsigned stall, calm;
      stall = 0;
      calm  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            stall = draw_gap(calm);
            rsp_bus.ready <= (stall == 0);
            if (stall > 0) stall--;
         end
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      coil_report_type want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.left_coils, rsp_bus.right_coils, rsp_bus.busy_res,
                rsp_bus.accepted, rsp_bus.done_res};
         if (expected_coils_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result beat: left %h right %h busy %b acc %b done %b",
                        got.left_coils, got.right_coils, got.busy_res, got.accepted,
                        got.done_res);
         end else begin
            want = expected_coils_q.pop_front();
            if (got.left_coils !== want.left_coils || got.right_coils !== want.right_coils
                || got.busy_res !== want.busy_res || got.accepted !== want.accepted
                || got.done_res !== want.done_res) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display({"result mismatch: expected left %h right %h busy %b acc %b ",
                            "done %b, got left %h right %h busy %b acc %b done %b"},
                           want.left_coils, want.right_coils, want.busy_res, want.accepted,
                           want.done_res, got.left_coils, got.right_coils, got.busy_res,
                           got.accepted, got.done_res);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         cycles <= cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_TICK;
      req_bus.motion   <= MOT_FORWARD;
      req_bus.amount   <= '0;
      half_period = 8'd2;
      mm_steps    = 8'd1;
      ang_small   = '0;
      ang_large   = '0;
      run_active  = 1'b0;
      run_motion  = MOT_FORWARD;
      run_steps   = '0;
      run_phase   = 2'd0;
      run_high    = 1'b0;
      run_ticks   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_power_on_defaults();
      test_step_wrap();
      test_turns();
      test_register_extremes();
      test_random_traffic();

      wait_bus_idle();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
